[rtl/crlf_pkg.sv]
package crlf_pkg;

  localparam int NUM_CHANNELS   = 2;
  localparam int CHAN_BITS      = 1;
  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_BITS      = 16;
  localparam int STATE_BITS     = 32;
  localparam int NUM_STAGES     = 5;
  localparam int CFG_ADDR_BITS  = 3;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_ENHANCED_MODE        = 3'd0,
    CFG_SWITCHABLE_FILTER_ON = 3'd1,
    CFG_COEF_SWITCHABLE      = 3'd2,
    CFG_COEF_STATIC_FIRST    = 3'd3,
    CFG_COEF_STATIC_SECOND   = 3'd4
  } cfg_reg_t;

  // word moving along the stage chain
  typedef struct packed {
    logic                         valid;
    logic [CHAN_BITS-1:0]         chan;
    logic signed [STATE_BITS-1:0] val;
  } tok_t;

  function automatic logic [COEF_BITS-1:0] clamp_coef(input logic [COEF_BITS-1:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

endpackage

[rtl/crlf_cell.sv]
module crlf_cell
  import crlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 bypass,
  input  logic [COEF_BITS-1:0] coef,
  input  tok_t                 din,
  output tok_t                 dout
);

  localparam int PROD_BITS = STATE_BITS + COEF_BITS + 2;

  logic signed [STATE_BITS-1:0] y [NUM_CHANNELS];
  logic                         busy;
  logic [CHAN_BITS-1:0]         ch;
  logic signed [STATE_BITS:0]   d;

  logic signed [PROD_BITS-1:0]            prod;
  logic signed [STATE_BITS+2:0]           step;
  logic signed [STATE_BITS+3:0]           sum;
  logic signed [STATE_BITS-1:0]           y_next;

  localparam logic signed [STATE_BITS+3:0] SMAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [STATE_BITS+3:0] SMIN = -36'sh0_8000_0000;

  always_comb begin
    prod = PROD_BITS'(d) * PROD_BITS'($signed({1'b0, coef}));
    step = prod[PROD_BITS-1:COEF_FRAC_BITS];
    sum  = {{4{y[ch][STATE_BITS-1]}}, y[ch]} + {step[STATE_BITS+2], step};
    if (sum > SMAX) begin
      y_next = SMAX[STATE_BITS-1:0];
    end else if (sum < SMIN) begin
      y_next = SMIN[STATE_BITS-1:0];
    end else begin
      y_next = sum[STATE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      dout.valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        y[i] <= '0;
      end
    end else begin
      dout.valid <= 1'b0;
      if (din.valid) begin
        if (bypass) begin
          dout.valid <= 1'b1;
          dout.chan  <= din.chan;
          dout.val   <= din.val;
        end else begin
          busy <= 1'b1;
          ch   <= din.chan;
          d    <= {din.val[STATE_BITS-1], din.val}
                - {y[din.chan][STATE_BITS-1], y[din.chan]};
        end
      end
      if (busy) begin
        busy       <= 1'b0;
        y[ch]      <= y_next;
        dout.valid <= 1'b1;
        dout.chan  <= ch;
        dout.val   <= y_next;
      end
    end
  end

endmodule

[rtl/cascaded_rc_lowpass_filter_core.sv]
// channel | dir | handshake                     | payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata sample_in, tuser chan
// m_axis  | out | m_axis_tvalid / m_axis_tready | tdata sample_out
// cfg     | in  | cfg_we                        | cfg_addr, cfg_data
// an accepted word runs through five stage cells; an active cell registers the difference,
// then multiplies, accumulates and registers the result; a bypassed one registers the word as is
// the result goes to the output register, or to the skid register, as it leaves the last cell
// one word is in the cell chain at a time; the next is taken once the result leaves it and the skid register is empty
// a result held by a stalled output goes to a skid register, so the chain never stalls
// rst is synchronous and clears the stage states, the config registers and the valid and busy flags
module cascaded_rc_lowpass_filter_core
  import crlf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,   // [15:0] sample_in
  input  logic [CHAN_BITS-1:0]     s_axis_tuser,   // [0] chan
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [SAMPLE_BITS-1:0]   m_axis_tdata,   // [15:0] sample_out
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COEF_BITS-1:0]     cfg_data
);

  logic                 enhanced_mode;
  logic                 switchable_filter_on;
  logic [COEF_BITS-1:0] coef_switchable;
  logic [COEF_BITS-1:0] coef_static_first;
  logic [COEF_BITS-1:0] coef_static_second;

  logic busy;
  logic pend_valid;
  logic [SAMPLE_BITS-1:0] pend_data;
  logic signed [STATE_BITS-1:0] stat;

  tok_t                 tok       [NUM_STAGES+1];
  logic                 cell_byp  [NUM_STAGES];
  logic [COEF_BITS-1:0] cell_coef [NUM_STAGES];

  logic s_acc;
  logic m_acc;
  logic signed [STATE_BITS-1:0]    res;
  logic signed [SAMPLE_BITS:0]     q;
  logic [SAMPLE_BITS-1:0]          q_sat;

  localparam logic signed [SAMPLE_BITS:0] QMAX = 17'sh0_7FFF;
  localparam logic signed [SAMPLE_BITS:0] QMIN = -17'sh0_8000;

  assign s_axis_tready = !busy && !pend_valid;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enhanced_mode        <= 1'b0;
      switchable_filter_on <= 1'b0;
      coef_switchable      <= COEF_ONE;
      coef_static_first    <= COEF_ONE;
      coef_static_second   <= COEF_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENHANCED_MODE:        enhanced_mode        <= cfg_data[0];
        CFG_SWITCHABLE_FILTER_ON: switchable_filter_on <= cfg_data[0];
        CFG_COEF_SWITCHABLE:      coef_switchable      <= cfg_data;
        CFG_COEF_STATIC_FIRST:    coef_static_first    <= cfg_data;
        CFG_COEF_STATIC_SECOND:   coef_static_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage roles per mode
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      cell_byp[k]  = 1'b0;
      cell_coef[k] = clamp_coef(coef_switchable);
    end
    cell_byp[0]  = enhanced_mode;
    cell_byp[4]  = enhanced_mode;
    cell_coef[0] = clamp_coef(coef_static_first);
    if (!enhanced_mode) begin
      cell_coef[1] = clamp_coef(coef_static_second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= s_acc;
      if (s_acc) begin
        tok[0].chan <= s_axis_tuser;
        tok[0].val  <= {s_axis_tdata, {FRAC_BITS{1'b0}}};
      end
    end
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    crlf_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .bypass (cell_byp[k]),
      .coef   (cell_coef[k]),
      .din    (tok[k]),
      .dout   (tok[k+1])
    );
  end

  // static result is the sample itself in enhanced mode
  always_ff @(posedge clk) begin
    if (tok[2].valid) begin
      stat <= enhanced_mode ? tok[1].val : tok[2].val;
    end
  end

  // truncate toward zero, then saturate
  always_comb begin
    res = switchable_filter_on ? tok[NUM_STAGES].val : stat;
    q   = {res[STATE_BITS-1], res[STATE_BITS-1:FRAC_BITS]};
    if (res[STATE_BITS-1] && (res[FRAC_BITS-1:0] != '0)) begin
      q = q + 17'sd1;
    end
    if (q > QMAX) begin
      q_sat = QMAX[SAMPLE_BITS-1:0];
    end else if (q < QMIN) begin
      q_sat = QMIN[SAMPLE_BITS-1:0];
    end else begin
      q_sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        busy <= 1'b1;
      end
      if (m_acc) begin
        m_axis_tvalid <= pend_valid;
        m_axis_tdata  <= pend_data;
        pend_valid    <= 1'b0;
      end
      if (tok[NUM_STAGES].valid) begin
        busy <= 1'b0;
        if (!m_axis_tvalid || (m_acc && !pend_valid)) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= q_sat;
        end else begin
          pend_valid <= 1'b1;
          pend_data  <= q_sat;
        end
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> m_axis_tvalid)
    else $error("skid word held with output register empty");

  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_STAGES].valid |-> busy)
    else $error("chain produced a word with no item in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> busy && tok[0].valid)
    else $error("accepted word did not enter the chain");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_STAGES].valid |-> !pend_valid)
    else $error("result arrived with skid register full");

endmodule
